// File: hw/rtl/fhunt_pkg.sv
`default_nettype none

package fhunt_pkg;

    // frame buffer size, sets the overflow and length limits
    localparam int BUFFER_BYTES   = 512;
    localparam int CNT_W          = $clog2(BUFFER_BYTES);
    // decoded length: 16-bit field plus offset
    localparam int EXP_W          = 17;

    localparam logic [7:0] SYNC_BYTE = 8'h7E;
    localparam int SYNC_LEN       = 4;
    localparam int LEN_OFFSET     = 5;
    localparam int LEN_DONE_COUNT = 7;
    localparam int POS_W          = 9;

    localparam logic [EXP_W-1:0] LIMIT = EXP_W'(BUFFER_BYTES - 1);

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_SYNC,
        ST_BODY,
        ST_GOOD,
        ST_TOOBIG,
        ST_BADSUM,
        ST_OVERFLOW
    } t_status;

    typedef enum logic {
        MODE_HUNT,
        MODE_FRAME
    } t_mode;

    typedef logic [3:0][7:0] t_window;

    // outcome of one byte while hunting
    typedef struct packed {
        t_window    window;
        logic [1:0] count;
        logic       hit;
    } t_hunt_res;

    // per-frame running state
    typedef struct packed {
        logic [CNT_W-1:0] frame_count;
        logic [7:0]       length_low;
        logic [EXP_W-1:0] exp_len;
        logic [7:0]       xor_acc;
    } t_frame_state;

    // outcome of one byte inside a frame
    typedef struct packed {
        t_frame_state next;
        logic         done;
        t_status      status;
    } t_frame_res;

endpackage

`default_nettype wire

// File: hw/rtl/fhunt_hunt.sv
`default_nettype none

module fhunt_hunt import fhunt_pkg::*; (
    input  logic [7:0] i_data_byte,
    input  t_window    i_window,
    input  logic [1:0] i_count,
    output t_hunt_res  o_res
);

    t_window w;

    // write byte into window, test for full sync, slide on mismatch
    always_comb begin
        w             = i_window;
        w[i_count]    = i_data_byte;
        o_res.window  = w;
        o_res.count   = i_count + 2'd1;
        o_res.hit     = 1'b0;
        if (i_count == 2'd3) begin
            if (w[0] == SYNC_BYTE && w[1] == SYNC_BYTE &&
                w[2] == SYNC_BYTE && w[3] == SYNC_BYTE) begin
                o_res.hit   = 1'b1;
                o_res.count = 2'd0;
            end else if (w[1] == SYNC_BYTE) begin
                o_res.window[0] = w[1];
                o_res.window[1] = w[2];
                o_res.window[2] = w[3];
                o_res.count     = 2'd3;
            end else if (w[2] == SYNC_BYTE) begin
                o_res.window[0] = w[2];
                o_res.window[1] = w[3];
                o_res.count     = 2'd2;
            end else if (w[3] == SYNC_BYTE) begin
                o_res.window[0] = w[3];
                o_res.count     = 2'd1;
            end else begin
                o_res.count = 2'd0;
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/fhunt_frame.sv
`default_nettype none

module fhunt_frame import fhunt_pkg::*; (
    input  logic [7:0]   i_data_byte,
    input  t_frame_state i_state,
    output t_frame_res   o_res
);

    logic [CNT_W-1:0] fc;
    logic [EXP_W-1:0] fc_ext;
    logic             len_byte;

    always_comb begin
        fc       = i_state.frame_count + CNT_W'(1);
        fc_ext   = EXP_W'(fc);
        len_byte = (fc == CNT_W'(LEN_DONE_COUNT));

        // running state: count, checksum, length capture
        o_res.next.frame_count = fc;
        o_res.next.xor_acc     = i_state.xor_acc ^ i_data_byte;
        o_res.next.length_low  = (fc == CNT_W'(LEN_OFFSET + 1)) ? i_data_byte
                                                                 : i_state.length_low;
        o_res.next.exp_len     = len_byte ?
            EXP_W'({i_data_byte, i_state.length_low}) + EXP_W'(LEN_OFFSET) :
            i_state.exp_len;

        // end-of-frame decisions, length check first
        o_res.done   = 1'b1;
        o_res.status = ST_BODY;
        if (len_byte && o_res.next.exp_len >= LIMIT) begin
            o_res.status = ST_TOOBIG;
        end else if (fc_ext >= LIMIT) begin
            o_res.status = ST_OVERFLOW;
        end else if (fc_ext == o_res.next.exp_len) begin
            o_res.status = (o_res.next.xor_acc != 8'd0) ? ST_BADSUM : ST_GOOD;
        end else begin
            o_res.done   = 1'b0;
            o_res.status = ST_BODY;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/sync_length_xor_frame_hunter.sv
// Byte-serial deframer. It hunts for four 0x7E sync bytes, then counts frame
// bytes, takes a 16-bit little-endian length from frame bytes 5 and 6, XORs
// every byte and ends the frame at byte count length + 5 with a good or bad
// checksum status; too-large lengths and buffer overflow drop the frame.
// Every byte comes out once with its frame position and status. One byte is
// taken per clock while the output does not stall; each result passes the
// input register and then the result register around the per-byte decode
// logic. The result register holds while the output stalls, and a new
// byte is still taken as long as the input register can move on.

`default_nettype none

module sync_length_xor_frame_hunter import fhunt_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [7:0]          i_data_byte,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [7:0]          o_byte_out,
    output logic [POS_W-1:0]    o_byte_pos,
    output logic [2:0]          o_status
);

    logic               r_in_valid;
    logic [7:0]         r_in_byte;
    t_mode              r_mode;
    t_mode              n_mode;
    t_window            r_window;
    t_window            n_window;
    logic [1:0]         r_sync_count;
    logic [1:0]         n_sync_count;
    t_frame_state       r_frame;
    t_frame_state       n_frame;
    logic               r_out_valid;
    logic [7:0]         r_out_byte;
    logic [POS_W-1:0]   r_out_pos;
    logic [POS_W-1:0]   n_out_pos;
    t_status            r_out_status;
    t_status            n_out_status;

    logic               advance;
    logic               step;
    t_hunt_res          hunt_res;
    t_frame_res         frame_res;
    logic [CNT_W+POS_W-1:0] pos_ext;

    // pipeline flow control
    assign advance = !r_out_valid || !i_stall;
    assign step    = advance && r_in_valid;
    assign o_stall = r_in_valid && !advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
        if (!o_stall) begin
            r_in_byte <= i_data_byte;
        end
    end

    fhunt_hunt u_hunt (
        .i_data_byte (r_in_byte),
        .i_window    (r_window),
        .i_count     (r_sync_count),
        .o_res       (hunt_res)
    );

    fhunt_frame u_frame (
        .i_data_byte (r_in_byte),
        .i_state     (r_frame),
        .o_res       (frame_res)
    );

    // next mode
    always_comb begin
        n_mode = r_mode;
        case (r_mode)
            MODE_HUNT:  if (hunt_res.hit) begin
                n_mode = MODE_FRAME;
            end
            MODE_FRAME: if (frame_res.done) begin
                n_mode = MODE_HUNT;
            end
            default:    n_mode = MODE_HUNT;
        endcase
    end

    // datapath and result selection
    always_comb begin
        pos_ext      = {{POS_W{1'b0}}, r_frame.frame_count};
        n_window     = r_window;
        n_sync_count = r_sync_count;
        n_frame      = r_frame;
        n_out_pos    = '0;
        n_out_status = ST_HUNT;
        case (r_mode)
            MODE_HUNT: begin
                n_window     = hunt_res.window;
                n_sync_count = hunt_res.count;
                if (hunt_res.hit) begin
                    n_frame.frame_count = CNT_W'(SYNC_LEN);
                    n_frame.xor_acc     = 8'd0;
                    n_out_pos           = POS_W'(SYNC_LEN - 1);
                    n_out_status        = ST_SYNC;
                end
            end
            MODE_FRAME: begin
                n_frame      = frame_res.next;
                n_out_pos    = pos_ext[POS_W-1:0];
                n_out_status = frame_res.status;
            end
            default: begin
                n_out_status = ST_HUNT;
            end
        endcase
    end

    // block state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_HUNT;
            r_window     <= '0;
            r_sync_count <= 2'd0;
            r_frame      <= '0;
        end else if (step) begin
            r_mode       <= n_mode;
            r_window     <= n_window;
            r_sync_count <= n_sync_count;
            r_frame      <= n_frame;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
        if (step) begin
            r_out_byte   <= r_in_byte;
            r_out_pos    <= n_out_pos;
            r_out_status <= n_out_status;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_byte_out = r_out_byte;
    assign o_byte_pos = r_out_pos;
    assign o_status   = r_out_status;

`ifndef SYNTHESIS
    // input side only stalls behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held result");

    // hunting bytes carry no position
    a_hunt_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_HUNT) |-> (o_byte_pos == '0))
        else $error("hunting byte with nonzero position");

    // sync completion is always the fourth sync byte
    a_sync_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_SYNC) |->
            (o_byte_out == SYNC_BYTE && o_byte_pos == POS_W'(SYNC_LEN - 1)))
        else $error("sync status on wrong byte");

    // a frame in progress never holds a count at the buffer limit
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_FRAME) |-> (EXP_W'(r_frame.frame_count) < LIMIT))
        else $error("frame count past buffer limit");
`endif

endmodule

`default_nettype wire

// File: verif/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fhunt_pkg::*;

    localparam logic [7:0] SLIP_BYTE = 8'hFE;

    // one deframed byte as the block should report it
    typedef struct {
        logic [7:0]       data;
        logic [POS_W-1:0] pos;
        t_status          status;
    } t_deframed_byte;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_stall;
    logic [7:0]       i_data_byte;
    logic             o_valid;
    logic             i_stall;
    logic [7:0]       o_byte_out;
    logic [POS_W-1:0] o_byte_pos;
    logic [2:0]       o_status;

    // idle and hold-off controls for sender and receiver, byte and mismatch counters
    int unsigned tx_gap_pct     = 35;
    int unsigned rx_stall_pct   = 35;
    int unsigned rx_hold_cycles = 0;
    int unsigned bytes_sent     = 0;
    int unsigned mismatch_count = 0;

    // deframer state mirrored by the predictor
    t_mode            frm_mode  = MODE_HUNT;
    t_window          sync_win  = '0;
    logic [2:0]       sync_fill = '0;
    logic [CNT_W-1:0] frame_cnt = '0;
    logic [EXP_W-1:0] frame_end = '0;
    logic [7:0]       len_low   = '0;
    logic [7:0]       frame_xor = '0;

    t_deframed_byte predicted_bytes [$];

    sync_length_xor_frame_hunter i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data_byte (i_data_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_byte_out  (o_byte_out),
        .o_byte_pos  (o_byte_pos),
        .o_status    (o_status)
    );

    // 12 ns clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // next deframed byte, advances the mirrored state
    function automatic t_deframed_byte deframe_byte(input logic [7:0] b);
        t_deframed_byte r;
        int             shift;
        r.data   = b;
        r.pos    = '0;
        r.status = ST_HUNT;
        if (frm_mode == MODE_HUNT) begin
            sync_win[sync_fill[1:0]] = b;
            sync_fill = sync_fill + 3'd1;
            if (sync_fill < 3'(SYNC_LEN))
                return r;
            if (sync_win == {4{SYNC_BYTE}}) begin
                frm_mode  = MODE_FRAME;
                frame_cnt = CNT_W'(SYNC_LEN);
                sync_fill = '0;
                frame_xor = '0;
                r.pos     = POS_W'(SYNC_LEN - 1);
                r.status  = ST_SYNC;
                return r;
            end
            // slide the window to the first later sync byte, else empty it
            shift = 0;
            for (int k = SYNC_LEN - 1; k >= 1; k--)
                if (sync_win[k] == SYNC_BYTE)
                    shift = k;
            for (int k = 0; k < SYNC_LEN - shift; k++)
                sync_win[k] = sync_win[k + shift];
            sync_fill = (shift == 0) ? 3'd0 : 3'(SYNC_LEN - shift);
            return r;
        end

        // inside a frame
        r.pos     = POS_W'(frame_cnt);
        frame_cnt = frame_cnt + 1'b1;
        frame_xor = frame_xor ^ b;
        if (frame_cnt == LEN_OFFSET + 1)
            len_low = b;
        if (frame_cnt == LEN_DONE_COUNT) begin
            frame_end = EXP_W'({b, len_low}) + EXP_W'(LEN_OFFSET);
            if (frame_end >= LIMIT) begin
                frm_mode = MODE_HUNT;
                r.status = ST_TOOBIG;
                return r;
            end
        end
        if (EXP_W'(frame_cnt) >= LIMIT) begin
            frm_mode = MODE_HUNT;
            r.status = ST_OVERFLOW;
            return r;
        end
        if (EXP_W'(frame_cnt) == frame_end) begin
            frm_mode = MODE_HUNT;
            r.status = (frame_xor != 8'h00) ? ST_BADSUM : ST_GOOD;
            return r;
        end
        r.status = ST_BODY;
        return r;
    endfunction

    // predict on each input transaction, check each output transaction
    always @(posedge i_clk) begin : score_bytes
        t_deframed_byte want;
        if (i_rst_n && i_valid && !o_stall)
            predicted_bytes.push_back(deframe_byte(i_data_byte));
        if (i_rst_n && o_valid && !i_stall) begin
            if (predicted_bytes.size() == 0) begin
                $error("unexpected transaction: byte_out %02h byte_pos %0d status %0d",
                       o_byte_out, o_byte_pos, o_status);
                mismatch_count++;
            end else begin
                want = predicted_bytes.pop_front();
                if (o_byte_out !== want.data) begin
                    $error("byte_out mismatch: expected %02h, actual %02h",
                           want.data, o_byte_out);
                    mismatch_count++;
                end
                if (o_byte_pos !== want.pos) begin
                    $error("byte_pos mismatch: expected %0d, actual %0d",
                           want.pos, o_byte_pos);
                    mismatch_count++;
                end
                if (o_status !== want.status) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           want.status, o_status);
                    mismatch_count++;
                end
            end
        end
    end

    // receiver: random stalls, or a counted hold-off when requested
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_cycles > 0) begin
                i_stall = 1'b1;
                rx_hold_cycles--;
            end else begin
                i_stall = ($urandom_range(99) < rx_stall_pct);
            end
        end
    end

    // one input transaction, entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < tx_gap_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid     = 1'b1;
        i_data_byte = b;
        do @(posedge i_clk); while (o_stall);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // byte biased toward sync and slip values
    function automatic logic [7:0] any_byte();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 20)
            return SYNC_BYTE;
        if (roll < 30)
            return SLIP_BYTE;
        return 8'($urandom);
    endfunction

    task automatic send_noise(input int unsigned count);
        repeat (count) send_byte(any_byte());
    endtask

    // sync plus a frame carrying the given length field
    task automatic send_frame(input logic [15:0] flen, input bit good_sum);
        logic [7:0] body [$];
        logic [7:0] acc;
        int         count;
        int         fix;
        if (int'(flen) + LEN_OFFSET >= int'(LIMIT))
            count = LEN_DONE_COUNT - SYNC_LEN;
        else if (int'(flen) < LEN_DONE_COUNT - LEN_OFFSET)
            count = BUFFER_BYTES - 1 - SYNC_LEN;
        else
            count = int'(flen) + 1;
        repeat (count) body.push_back(any_byte());
        body[1] = flen[7:0];
        body[2] = flen[15:8];
        // last free byte sets the checksum, the type byte for the shortest frame
        fix       = (count > 3) ? count - 1 : 0;
        body[fix] = 8'h00;
        acc       = 8'h00;
        foreach (body[k])
            acc = acc ^ body[k];
        body[fix] = good_sum ? acc : acc ^ 8'($urandom_range(255, 1));
        repeat (SYNC_LEN) send_byte(SYNC_BYTE);
        foreach (body[k])
            send_byte(body[k]);
    endtask

    // window slides over near-miss sync patterns
    task automatic test_hunt_slip();
        logic [7:0] pattern [$];
        pattern = {8'h00, 8'hFF, SYNC_BYTE, SYNC_BYTE, SYNC_BYTE, SLIP_BYTE, SYNC_BYTE,
                   SYNC_BYTE, SLIP_BYTE, SYNC_BYTE, 8'h81, 8'h00, 8'h00};
        foreach (pattern[k])
            send_byte(pattern[k]);
    endtask

    // shortest good frame and a bad checksum
    task automatic test_frame_ends();
        send_frame(16'd2, 1'b1);
        send_frame(16'd3, 1'b0);
    endtask

    // length field extremes, smallest length that hits the buffer limit
    task automatic test_length_limits();
        send_frame(16'hFFFF, 1'b0);
        send_frame(16'(BUFFER_BYTES - 1 - LEN_OFFSET), 1'b1);
    endtask

    // output held off while input keeps coming, block must fill and stall
    task automatic test_output_backpressure();
        tx_gap_pct     = 0;
        rx_hold_cycles = 80;
        send_frame(16'd30, 1'b1);
        tx_gap_pct     = 35;
    endtask

    // mostly well-formed frames, some broken syncs and line noise
    task automatic test_random_traffic();
        int unsigned stop_at;
        int unsigned roll;
        logic [15:0] flen;
        stop_at = bytes_sent + 280;
        while (bytes_sent < stop_at) begin
            // middle stretch runs with no idling on either side
            if (stop_at - bytes_sent < 200 && stop_at - bytes_sent >= 80) begin
                tx_gap_pct   = 0;
                rx_stall_pct = 0;
            end else begin
                tx_gap_pct   = 35;
                rx_stall_pct = 35;
            end
            roll = $urandom_range(99);
            if (roll < 70) begin
                send_noise($urandom_range(3));
                if ($urandom_range(19) == 0)
                    flen = 16'($urandom_range(200, 41));
                else
                    flen = 16'($urandom_range(40, 2));
                send_frame(flen, $urandom_range(9) < 7);
            end else if (roll < 78) begin
                send_frame(16'($urandom_range(65535, BUFFER_BYTES - 1 - LEN_OFFSET)), 1'b0);
            end else if (roll < 88) begin
                repeat ($urandom_range(7, 3))
                    send_byte(($urandom_range(3) != 0) ? SYNC_BYTE : SLIP_BYTE);
            end else begin
                send_noise($urandom_range(8, 1));
            end
        end
        tx_gap_pct   = 35;
        rx_stall_pct = 35;
    endtask

    // overflow leaves a small length behind, later frames end early on it
    task automatic test_overflow_stale_length();
        send_frame(16'd0, 1'b0);
        send_frame(16'd9, 1'b1);
        send_frame(16'd12, 1'b1);
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data_byte = 8'h00;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_hunt_slip();
        test_frame_ends();
        test_length_limits();
        test_output_backpressure();
        test_random_traffic();
        test_overflow_stale_length();

        // drain outstanding results
        i_valid = 1'b0;
        while (predicted_bytes.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("** sync_length_xor_frame_hunter: PASSED **");
        else
            $display("** sync_length_xor_frame_hunter: FAILED **");
        $finish;
    end

    // watchdog
    initial begin
        #3_000_000;
        $display("** sync_length_xor_frame_hunter: FAILED **");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/fhunt_pkg.sv
hw/rtl/fhunt_hunt.sv
hw/rtl/fhunt_frame.sv
hw/rtl/sync_length_xor_frame_hunter.sv
verif/tb.sv
